// ===== hw/rtl/spi_rm_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI register access master package
// Frame phase codes, request and command codes, and frame size, fill and reset
// constants shared by the register access master.
// ----------------------------------------------------------------------------
package spi_rm_pkg;

	localparam int unsigned HEADER_BITS = 10;
	localparam int unsigned BYTE_BITS   = 8;
	localparam int unsigned WORD_BYTES  = 4;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	localparam logic [1:0] CMD_READ  = 2'h1;
	localparam logic [1:0] CMD_WRITE = 2'h2;
	localparam logic [7:0] FILL_BYTE = 8'hFF;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd3600;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_WAIT   = 4'b0100,
		PH_DATA   = 4'b1000
	} phase_t;

endpackage

// ===== hw/rtl/spi_register_access_master.sv =====
// ----------------------------------------------------------------------------
// SPI register access master
// Mode-0, LSB-first SPI master that runs one register read or write frame.
// Each accepted input transfer is one tick of the serial timing base.
// ----------------------------------------------------------------------------
// Result: the output registers, loaded from the next frame state alongside the
// frame state register, show the result for a transfer in the cycle after it is accepted.
// Throughput: one transfer per cycle; input stalls only while a finished
// result is held by a stalled output.
// Reset: frame idle, chip select high, half_period set to 3600 ticks.
module spi_register_access_master #(
	parameter int unsigned WAIT_BYTES = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [15:0]               cfg_data,

	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic [7:0]                reg_addr,
	input  logic [31:0]               write_word,
	input  logic [7:0]                read_count,
	input  logic                      miso,

	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      cs_n,
	output logic                      sck,
	output logic                      mosi,
	output logic                      rx_valid,
	output logic [7:0]                rx_byte,
	output logic                      frame_done,
	output logic                      busy_res
);
	import spi_rm_pkg::*;

	localparam int unsigned WAIT_W = $clog2(WAIT_BYTES + 2);

	typedef struct packed {
		phase_t              phase;
		logic                is_write;
		logic [31:0]         tx_shift;
		logic [7:0]          rx_shift;
		logic [3:0]          bit_index;
		logic [7:0]          bytes_left;
		logic [15:0]         tick_count;
		logic                clock_high;
		logic [HEADER_BITS-1:0] hdr_bits;
		logic [WAIT_W-1:0]   wait_left;
	} frame_t;

	frame_t      state_q;
	frame_t      state_nxt;
	logic [15:0] half_period_q;
	logic        out_valid_q;
	logic        accept;
	logic        rx_valid_nxt;
	logic [7:0]  rx_byte_nxt;
	logic        done_nxt;
	logic        mosi_nxt;

	logic        cs_n_q;
	logic        sck_q;
	logic        mosi_q;
	logic        rx_valid_q;
	logic [7:0]  rx_byte_q;
	logic        frame_done_q;
	logic        busy_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;

	always_comb begin
		state_nxt    = state_q;
		rx_valid_nxt = 1'b0;
		rx_byte_nxt  = '0;
		done_nxt     = 1'b0;
		if (state_q.phase == PH_IDLE) begin
			if (req_type == REQ_READ || req_type == REQ_WRITE) begin
				state_nxt.is_write   = (req_type == REQ_WRITE);
				state_nxt.hdr_bits   = {reg_addr,
					(req_type == REQ_WRITE) ? CMD_WRITE : CMD_READ};
				state_nxt.tx_shift   = (req_type == REQ_WRITE) ? write_word : 32'd0;
				state_nxt.bytes_left = (req_type == REQ_WRITE) ?
					8'(WORD_BYTES) : read_count;
				state_nxt.wait_left  = (req_type == REQ_WRITE) ?
					'0 : WAIT_W'(WAIT_BYTES);
				state_nxt.rx_shift   = '0;
				state_nxt.bit_index  = '0;
				state_nxt.tick_count = '0;
				state_nxt.clock_high = 1'b0;
				state_nxt.phase      = PH_HEADER;
			end
		end else begin
			state_nxt.tick_count = state_q.tick_count + 16'd1;
			if (state_nxt.tick_count >= half_period_q) begin
				state_nxt.tick_count = '0;
				if (!state_q.clock_high) begin
					if (state_q.phase == PH_DATA && !state_q.is_write) begin
						state_nxt.rx_shift[state_q.bit_index[2:0]] = miso;
					end
					state_nxt.clock_high = 1'b1;
				end else begin
					state_nxt.clock_high = 1'b0;
					state_nxt.bit_index  = state_q.bit_index + 4'd1;
					if (state_q.phase == PH_HEADER) begin
						state_nxt.hdr_bits = state_q.hdr_bits >> 1;
						if (state_nxt.bit_index == 4'(HEADER_BITS)) begin
							state_nxt.bit_index = '0;
							if (state_q.is_write) begin
								state_nxt.phase = PH_DATA;
							end else if (state_q.wait_left != '0) begin
								state_nxt.phase = PH_WAIT;
							end else if (state_q.bytes_left != '0) begin
								state_nxt.phase = PH_DATA;
							end else begin
								done_nxt = 1'b1;
							end
						end
					end else begin
						if (state_q.is_write) begin
							state_nxt.tx_shift = state_q.tx_shift >> 1;
						end
						if (state_nxt.bit_index == 4'(BYTE_BITS)) begin
							state_nxt.bit_index = '0;
							if (state_q.phase == PH_WAIT) begin
								state_nxt.wait_left = state_q.wait_left - WAIT_W'(1);
								if (state_nxt.wait_left == '0) begin
									if (state_q.bytes_left != '0) begin
										state_nxt.phase = PH_DATA;
									end else begin
										done_nxt = 1'b1;
									end
								end
							end else begin
								if (!state_q.is_write) begin
									rx_valid_nxt = 1'b1;
									rx_byte_nxt  = state_nxt.rx_shift;
								end
								state_nxt.rx_shift   = '0;
								state_nxt.bytes_left = state_q.bytes_left - 8'd1;
								if (state_nxt.bytes_left == '0) begin
									done_nxt = 1'b1;
								end
							end
						end
					end
				end
			end
			if (done_nxt) begin
				state_nxt.phase      = PH_IDLE;
				state_nxt.clock_high = 1'b0;
				state_nxt.tick_count = '0;
				state_nxt.bit_index  = '0;
				state_nxt.rx_shift   = '0;
				state_nxt.hdr_bits   = '0;
			end
		end
	end

	always_comb begin
		case (state_nxt.phase)
			PH_HEADER: mosi_nxt = state_nxt.hdr_bits[0];
			PH_WAIT:   mosi_nxt = FILL_BYTE[0];
			PH_DATA:   mosi_nxt = state_nxt.is_write ? state_nxt.tx_shift[0] : FILL_BYTE[0];
			default:   mosi_nxt = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q      <= HALF_PERIOD_RESET;
			state_q.phase      <= PH_IDLE;
			state_q.is_write   <= 1'b0;
			state_q.tx_shift   <= '0;
			state_q.rx_shift   <= '0;
			state_q.bit_index  <= '0;
			state_q.bytes_left <= '0;
			state_q.tick_count <= '0;
			state_q.clock_high <= 1'b0;
			state_q.hdr_bits   <= '0;
			state_q.wait_left  <= '0;
			out_valid_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				half_period_q <= cfg_data;
			end
			if (accept) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_n_q       <= 1'b1;
			sck_q        <= 1'b0;
			mosi_q       <= 1'b0;
			rx_valid_q   <= 1'b0;
			rx_byte_q    <= '0;
			frame_done_q <= 1'b0;
			busy_q       <= 1'b0;
		end else if (accept) begin
			cs_n_q       <= (state_nxt.phase == PH_IDLE);
			sck_q        <= state_nxt.clock_high;
			mosi_q       <= mosi_nxt;
			rx_valid_q   <= rx_valid_nxt;
			rx_byte_q    <= rx_byte_nxt;
			frame_done_q <= done_nxt;
			busy_q       <= (state_nxt.phase != PH_IDLE);
		end
	end

	assign out_valid  = out_valid_q;
	assign cs_n       = cs_n_q;
	assign sck        = sck_q;
	assign mosi       = mosi_q;
	assign rx_valid   = rx_valid_q;
	assign rx_byte    = rx_byte_q;
	assign frame_done = frame_done_q;
	assign busy_res   = busy_q;

	// An idle frame keeps its serial clock low and its tick counter cleared.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_IDLE |-> !state_q.clock_high && state_q.tick_count == '0)
		else $error("idle frame with running serial clock");

	// A frame end shown on the output always comes with chip select released.
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_done_q |-> cs_n_q && !busy_q && !sck_q)
		else $error("frame end without chip select release");

	// Received bytes only come out of read frames.
	a_rx_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rx_valid_q |-> !state_q.is_write)
		else $error("received byte during a write frame");

	// The input side stalls only while a result is held.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with empty output register");

	// A transfer accepted under stall never happens, so a held result stays put.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(busy_q) && $stable(sck_q))
		else $error("held result changed under stall");

endmodule
